[design/gamepad_frame_parser_assert.svh]
// Assertion macros for the gamepad frame parser.
`ifndef GAMEPAD_FRAME_PARSER_ASSERT_SVH
`define GAMEPAD_FRAME_PARSER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define GFP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gamepad_frame_parser: implication check failed");
// next-cycle implication
`define GFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gamepad_frame_parser: next-cycle check failed");
`else
`define GFP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define GFP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[design/gfp_pkg.sv]
// Shared constants, types and helpers for the gamepad frame parser.
package gfp_pkg;

  localparam int BUF_DEPTH = 16;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  localparam logic [CNT_W-1:0] HEX_NEED = CNT_W'(12);
  localparam logic [CNT_W-1:0] DEC_NEED = CNT_W'(16);

  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_KEY_LOW    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_HIGH   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HOLD_TICKS = 2'd2;

  localparam logic [15:0] HOLD_RESET = 16'd100;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] ALPHA_OFS = 8'd55;
  localparam logic [7:0] PWM_MAX   = 8'd255;

  localparam logic [3:0] DIR_FWD  = 4'b1010;
  localparam logic [3:0] DIR_REV  = 4'b0101;
  localparam logic [3:0] DIR_STOP = 4'b0000;

  typedef struct packed {
    logic [63:0] key_low;
    logic [15:0] key_high;
    logic [15:0] hold_ticks;
  } gfp_cfg_t;

  typedef struct packed {
    logic       keypad;
    logic       joy;
    logic       is_dec;
    logic [7:0] key;
  } gfp_event_t;

  typedef struct packed {
    logic start;
    logic is_dec;
  } gfp_dec_ctrl_t;

  function automatic logic is_key(input logic [7:0] b, input logic [63:0] lo,
                                  input logic [15:0] hi);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (lo[8*i +: 8] == b) hit = 1'b1;
    end
    if (hi[7:0] == b || hi[15:8] == b) hit = 1'b1;
    return hit;
  endfunction

endpackage

[design/gfp_cfg.sv]
// APB register file: key codes and hold time.
module gfp_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [gfp_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready,
  output gfp_pkg::gfp_cfg_t         cfg
);
  import gfp_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign idx    = paddr[ADDR_W-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_low    <= '0;
      cfg.key_high   <= '0;
      cfg.hold_ticks <= HOLD_RESET;
    end else if (wr) begin
      case (idx)
        REG_KEY_LOW:    cfg.key_low    <= pwdata;
        REG_KEY_HIGH:   cfg.key_high   <= pwdata[15:0];
        REG_HOLD_TICKS: cfg.hold_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KEY_LOW:    prdata = cfg.key_low;
      REG_KEY_HIGH:   prdata = {48'd0, cfg.key_high};
      REG_HOLD_TICKS: prdata = {48'd0, cfg.hold_ticks};
      default:        prdata = '0;
    endcase
  end

endmodule

[design/gfp_frame.sv]
// Frame buffer with byte intake, hold timer and frame classification.
module gfp_frame (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       action,
  input  logic [7:0]                 rx_byte,
  input  gfp_pkg::gfp_cfg_t          cfg,
  input  logic                       clear,
  input  logic [gfp_pkg::BUF_AW-1:0] rd_addr,
  output logic [7:0]                 rd_data,
  output gfp_pkg::gfp_event_t        evt
);
  import gfp_pkg::*;

  typedef enum logic [3:0] {
    FK_EMPTY = 4'b0001,
    FK_HOLD  = 4'b0010,
    FK_HEX   = 4'b0100,
    FK_DEC   = 4'b1000
  } fk_t;

  logic [7:0]       fb [BUF_DEPTH];
  logic [CNT_W-1:0] cnt, cnt_next, cnt1;
  fk_t              kind, kind_next, kind1;
  logic [15:0]      elapsed, elapsed_next, el1;
  logic             wr_en;
  logic [BUF_AW-1:0] wr_addr;
  logic [7:0]       b0, b3;
  logic [CNT_W-1:0] need;

  assign rd_data = fb[rd_addr];

  always_comb begin
    kind1   = kind;
    cnt1    = cnt;
    el1     = elapsed;
    wr_en   = 1'b0;
    wr_addr = cnt[BUF_AW-1:0];
    // intake
    if (!action) begin
      if (kind == FK_EMPTY) begin
        if (is_key(rx_byte, cfg.key_low, cfg.key_high)) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          cnt1    = CNT_W'(1);
          kind1   = FK_HOLD;
          el1     = '0;
        end
      end else if (cnt >= CNT_W'(BUF_DEPTH)) begin
        cnt1  = '0;
        kind1 = FK_EMPTY;
        el1   = '0;
      end else begin
        wr_en = 1'b1;
        cnt1  = cnt + CNT_W'(1);
      end
    end else if (kind == FK_HOLD && elapsed != 16'hFFFF) begin
      el1 = elapsed + 16'd1;
    end

    b0 = (wr_en && wr_addr == BUF_AW'(0)) ? rx_byte : fb[0];
    b3 = (wr_en && wr_addr == BUF_AW'(3)) ? rx_byte : fb[3];

    kind_next    = kind1;
    cnt_next     = cnt1;
    elapsed_next = el1;
    evt.keypad   = 1'b0;
    evt.joy      = 1'b0;
    // classification once the hold time has run
    if (kind1 == FK_HOLD && el1 >= cfg.hold_ticks) begin
      if (cnt1 == CNT_W'(1)) begin
        evt.keypad   = 1'b1;
        kind_next    = FK_EMPTY;
        cnt_next     = '0;
        elapsed_next = '0;
      end else if (b0 == cfg.key_low[7:0]) begin
        if (cnt1 > CNT_W'(3)) kind_next = (b3 == cfg.key_low[15:8]) ? FK_HEX : FK_DEC;
      end else begin
        kind_next    = FK_EMPTY;
        cnt_next     = '0;
        elapsed_next = '0;
      end
    end

    need = (kind_next == FK_HEX) ? HEX_NEED : DEC_NEED;
    if (kind_next == FK_HEX || kind_next == FK_DEC) begin
      if (cnt_next == need) begin
        evt.joy = 1'b1;       // frame kept until the decoder finishes
      end else if (cnt_next > need) begin
        kind_next    = FK_EMPTY;
        cnt_next     = '0;
        elapsed_next = '0;
      end
    end
    evt.is_dec = (kind_next == FK_DEC);
    evt.key    = b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      kind    <= FK_EMPTY;
      elapsed <= '0;
    end else if (clear) begin
      cnt     <= '0;
      kind    <= FK_EMPTY;
      elapsed <= '0;
    end else if (accept) begin
      cnt     <= cnt_next;
      kind    <= kind_next;
      elapsed <= elapsed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) fb[wr_addr] <= rx_byte;
  end

endmodule

[design/gfp_decode.sv]
// Joystick decoder: one shared digit accumulator walked over the field bytes.
module gfp_decode (
  input  logic                       clk,
  input  logic                       rst,
  input  gfp_pkg::gfp_dec_ctrl_t     ctrl,
  output logic [gfp_pkg::BUF_AW-1:0] rd_addr,
  input  logic [7:0]                 rd_data,
  output logic                       done,
  output logic [3:0]                 held_dir,
  output logic [7:0]                 held_left,
  output logic [7:0]                 held_right
);
  import gfp_pkg::*;

  typedef enum logic [2:0] {
    DS_IDLE = 3'b001,
    DS_BYTE = 3'b010,
    DS_MIX  = 3'b100
  } ds_t;

  ds_t         st;
  logic        is_dec;
  logic [1:0]  pos;
  logic [1:0]  fld;
  logic [7:0]  val, val_next;
  logic        nz;
  logic [2:0]  zeros, zeros_next;
  logic        turn;
  logic        last_byte;
  logic        digit;
  logic [7:0]  shifted, addend;
  logic [7:0]  inv;

  // shared unit: value*10 or value<<4, plus the digit's worth
  always_comb begin
    digit   = rd_data inside {[CH_ZERO:CH_NINE]};
    shifted = (digit && is_dec) ? ({val[4:0], 3'b000} + {val[6:0], 1'b0})
                                : {val[3:0], 4'b0000};
    addend  = digit ? {4'b0000, rd_data[3:0]} : (rd_data - ALPHA_OFS);
    val_next = shifted + addend;
  end

  assign last_byte  = (pos == (is_dec ? 2'd2 : 2'd1));
  assign done       = (st == DS_MIX) && (fld == 2'd3);
  assign zeros_next = zeros + 3'd1;
  assign inv        = (val == PWM_MAX) ? PWM_MAX : ~val;

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= DS_IDLE;
      held_dir   <= DIR_STOP;
      held_left  <= '0;
      held_right <= '0;
      turn       <= 1'b0;
    end else begin
      case (st)
        DS_IDLE: begin
          if (ctrl.start) begin
            is_dec  <= ctrl.is_dec;
            rd_addr <= BUF_AW'(1);
            pos     <= '0;
            fld     <= '0;
            val     <= '0;
            nz      <= 1'b0;
            zeros   <= '0;
            st      <= DS_BYTE;
          end
        end
        DS_BYTE: begin
          val <= val_next;
          nz  <= nz || (rd_data != CH_ZERO);
          if (last_byte) begin
            rd_addr <= rd_addr + BUF_AW'(2);   // skip the separator byte
            st      <= DS_MIX;
          end else begin
            rd_addr <= rd_addr + BUF_AW'(1);
            pos     <= pos + 2'd1;
          end
        end
        DS_MIX: begin
          if (nz) begin
            if (!fld[1]) begin
              turn       <= fld[0];
              held_left  <= inv;
              held_right <= inv;
            end else begin
              if (!turn) begin
                if (val > held_right) held_right <= val;
                else held_left <= val;
              end else begin
                if (val > held_left) held_left <= val;
                else held_right <= val;
              end
              held_dir <= (fld == 2'd2) ? DIR_FWD : DIR_REV;
            end
          end else begin
            zeros <= zeros_next;
            if (zeros_next == 3'd3) begin
              held_dir   <= DIR_STOP;
              held_left  <= '0;
              held_right <= '0;
            end
          end
          val <= '0;
          nz  <= 1'b0;
          pos <= '0;
          fld <= fld + 2'd1;
          st  <= (fld == 2'd3) ? DS_IDLE : DS_BYTE;
        end
        default: st <= DS_IDLE;
      endcase
    end
  end

endmodule

[design/gamepad_frame_parser.sv]
// Top level of the gamepad frame parser: sequencer, output register, assertions.
//
//  channel  | handshake           | beat contents
//  ---------+---------------------+-------------------------------------------
//  in       | in_valid / in_stall | action, rx_byte
//  out      | out_valid/out_stall | kind, key_code, direction, left_pwm, right_pwm
//  cfg      | APB psel/penable    | paddr, pwdata, prdata (64 bit), pready
//
// A byte or tick beat that yields no result is taken without stalling the input.
// A keypad result passes through intake, then handoff to the output register.
// A completed joystick frame, hex or decimal, is decoded over four fields: the decoder
// reads one field byte per cycle through the shared digit accumulator, then mixes
// each field in its own mix step.
// Handoff waits while out_stall holds a full output register; in_stall is high
// from the intake of a result-bearing beat until its handoff.
// rst is synchronous: control state and control registers return to reset values at once;
// the frame buffer needs no clearing pass (the fill count gates every read).
module gamepad_frame_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       action,
  input  logic [7:0]                 rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       kind,
  output logic [7:0]                 key_code,
  output logic [3:0]                 direction,
  output logic [7:0]                 left_pwm,
  output logic [7:0]                 right_pwm,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gfp_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);
  import gfp_pkg::*;

`include "gamepad_frame_parser_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DECODE = 3'b010,
    ST_PUT    = 3'b100
  } st_t;

  st_t           st;
  gfp_cfg_t      cfg;
  gfp_event_t    evt;
  gfp_dec_ctrl_t dec_ctrl;
  logic          in_acc;
  logic          dec_done;
  logic [BUF_AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic [3:0]    held_dir;
  logic [7:0]    held_left, held_right;
  logic          res_joy;
  logic [7:0]    res_key;
  logic          load;

  assign in_stall = (st != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign dec_ctrl.start  = in_acc && evt.joy;
  assign dec_ctrl.is_dec = evt.is_dec;

  // result moves into the output register when it is empty or draining
  assign load = (st == ST_PUT) && (!out_valid || !out_stall);

  gfp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gfp_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_acc),
    .action  (action),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .clear   (dec_done),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .evt     (evt)
  );

  gfp_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (dec_ctrl),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .done       (dec_done),
    .held_dir   (held_dir),
    .held_left  (held_left),
    .held_right (held_right)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      case (st)
        ST_IDLE: begin
          if (in_acc && evt.keypad) begin
            res_joy <= 1'b0;
            res_key <= evt.key;
            st      <= ST_PUT;
          end else if (dec_ctrl.start) begin
            st <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          if (dec_done) begin
            res_joy <= 1'b1;
            st      <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (load) st <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind      <= res_joy;
      key_code  <= res_joy ? 8'd0 : res_key;
      direction <= res_joy ? held_dir : DIR_STOP;
      left_pwm  <= res_joy ? held_left : 8'd0;
      right_pwm <= res_joy ? held_right : 8'd0;
    end
  end

  // a beat never triggers both a keypad result and a joystick decode
  `GFP_ASSERT_IMPL(a_evt_excl, clk, rst, in_acc, !(evt.keypad && evt.joy))
  // the decoder only finishes while the sequencer waits on it
  `GFP_ASSERT_IMPL(a_done_in_decode, clk, rst, dec_done, st == ST_DECODE)
  // a handoff always leaves a valid beat at the output
  `GFP_ASSERT_NEXT(a_put_loads, clk, rst, load, out_valid)

endmodule

[tb/gfp_tb_pkg.sv]
// Testbench codes shared by the stimulus top and the report checker.
`timescale 1ns / 100ps

package gfp_tb_pkg;

  // input beat type
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // result beat type
  localparam logic KIND_KEYPAD = 1'b0;
  localparam logic KIND_JOY    = 1'b1;

  // key code slots, low register bytes 0..7 then high register bytes 0..1
  typedef enum int {
    KEY_LEFT = 0, KEY_RIGHT, KEY_UP, KEY_DOWN, KEY_SELECT,
    KEY_START, KEY_A, KEY_B, KEY_Y, KEY_X
  } key_slot_e;

endpackage

[tb/gfp_report_checker.sv]
// Report checker: mirrors the frame parser per accepted beat and checks every result beat.
`timescale 1ns / 100ps

module gfp_report_checker
  import gfp_tb_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       action,
  input  logic [7:0]                 rx_byte,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       kind,
  input  logic [7:0]                 key_code,
  input  logic [3:0]                 direction,
  input  logic [7:0]                 left_pwm,
  input  logic [7:0]                 right_pwm,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [gfp_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  output int                         pending,
  output int                         errors
);

  typedef struct packed {
    logic       kind;
    logic [7:0] key_code;
    logic [3:0] direction;
    logic [7:0] left_pwm;
    logic [7:0] right_pwm;
  } pad_report_t;

  typedef enum logic [2:0] {
    FRAME_EMPTY, FRAME_HOLD, FRAME_KEYPAD, FRAME_HEX, FRAME_DEC
  } frame_phase_e;

  // register copies
  logic [63:0]  keys_low;
  logic [15:0]  keys_high;
  logic [15:0]  hold_limit;

  // parser state copy
  logic [7:0]   frame_buf [gfp_pkg::BUF_DEPTH];
  int unsigned  fill;
  frame_phase_e phase;
  logic [15:0]  elapsed;
  logic [3:0]   motor_dir;
  logic [7:0]   motor_left;
  logic [7:0]   motor_right;
  logic         turn_side;

  pad_report_t  due_reports [$];
  int           miss_count;

  function automatic logic [7:0] slot_code(int slot);
    return (slot < 8) ? keys_low[8*slot +: 8] : keys_high[8*(slot-8) +: 8];
  endfunction

  function automatic logic is_pad_key(logic [7:0] b);
    logic hit;
    hit = 1'b0;
    for (int s = 0; s < 10; s++)
      if (slot_code(s) == b) hit = 1'b1;
    return hit;
  endfunction

  function automatic logic [7:0] buf_byte(int unsigned p);
    return (p < gfp_pkg::BUF_DEPTH) ? frame_buf[p] : 8'h00;
  endfunction

  function automatic void clear_frame();
    foreach (frame_buf[i]) frame_buf[i] = 8'h00;
    fill    = 0;
    phase   = FRAME_EMPTY;
    elapsed = '0;
  endfunction

  // decode the four numeric fields and mix them into direction and duty
  function automatic void mix_motor_fields(int unsigned len);
    int unsigned zeros;
    logic        content;
    logic [7:0]  v;
    logic [7:0]  c;
    logic [7:0]  duty;
    zeros = 0;
    for (int unsigned h = 0; h < 4; h++) begin
      content = 1'b0;
      v = 8'h00;
      for (int unsigned p = h*len + 1; p % len != 0; p++) begin
        c = buf_byte(p);
        if (c != gfp_pkg::CH_ZERO) content = 1'b1;
        if (c >= gfp_pkg::CH_ZERO && c <= gfp_pkg::CH_NINE)
          v = ((len == 4) ? v * 8'd10 : v << 4) + {4'h0, c[3:0]};
        else
          v = (v << 4) + (c - gfp_pkg::ALPHA_OFS);
      end
      if (content) begin
        if (h < 2) begin
          turn_side = h[0];
          duty = (v == gfp_pkg::PWM_MAX) ? gfp_pkg::PWM_MAX : gfp_pkg::PWM_MAX - v;
          motor_left  = duty;
          motor_right = duty;
        end else begin
          if (turn_side == 1'b0) begin
            if (v > motor_right) motor_right = v;
            else motor_left = v;
          end else begin
            if (v > motor_left) motor_left = v;
            else motor_right = v;
          end
          motor_dir = (h == 2) ? gfp_pkg::DIR_FWD : gfp_pkg::DIR_REV;
        end
      end else begin
        zeros++;
        if (zeros == 3) begin
          motor_dir   = gfp_pkg::DIR_STOP;
          motor_left  = 8'h00;
          motor_right = 8'h00;
        end
      end
    end
  endfunction

  function automatic void parse_beat(logic act, logic [7:0] b);
    pad_report_t rep;
    int unsigned len;
    if (act == ACT_BYTE) begin
      if (phase == FRAME_EMPTY) begin
        if (is_pad_key(b)) begin
          frame_buf[0] = b;
          fill    = 1;
          phase   = FRAME_HOLD;
          elapsed = '0;
        end
      end else if (fill >= gfp_pkg::BUF_DEPTH) begin
        clear_frame();
      end else begin
        frame_buf[fill] = b;
        fill++;
      end
    end else if (phase == FRAME_HOLD && elapsed != 16'hFFFF) begin
      elapsed++;
    end

    if (phase == FRAME_HOLD && elapsed >= hold_limit) begin
      if (fill == 1)
        phase = FRAME_KEYPAD;
      else if (frame_buf[0] == slot_code(KEY_LEFT)) begin
        if (fill > 3)
          phase = (frame_buf[3] == slot_code(KEY_RIGHT)) ? FRAME_HEX : FRAME_DEC;
      end else
        clear_frame();
    end

    if (phase == FRAME_KEYPAD) begin
      rep.kind      = KIND_KEYPAD;
      rep.key_code  = frame_buf[0];
      rep.direction = gfp_pkg::DIR_STOP;
      rep.left_pwm  = 8'h00;
      rep.right_pwm = 8'h00;
      due_reports.push_back(rep);
      clear_frame();
    end else if (phase == FRAME_HEX || phase == FRAME_DEC) begin
      len = (phase == FRAME_HEX) ? 3 : 4;
      if (fill == 4*len) begin
        mix_motor_fields(len);
        rep.kind      = KIND_JOY;
        rep.key_code  = 8'h00;
        rep.direction = motor_dir;
        rep.left_pwm  = motor_left;
        rep.right_pwm = motor_right;
        due_reports.push_back(rep);
        clear_frame();
      end else if (fill > 4*len) begin
        clear_frame();
      end
    end
  endfunction

  always @(posedge clk) begin
    pad_report_t exp_rep;
    if (rst) begin
      keys_low    = '0;
      keys_high   = '0;
      hold_limit  = gfp_pkg::HOLD_RESET;
      clear_frame();
      motor_dir   = gfp_pkg::DIR_STOP;
      motor_left  = 8'h00;
      motor_right = 8'h00;
      turn_side   = 1'b0;
      due_reports.delete();
      miss_count  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[gfp_pkg::ADDR_W-1:3])
          gfp_pkg::REG_KEY_LOW:    keys_low   = pwdata;
          gfp_pkg::REG_KEY_HIGH:   keys_high  = pwdata[15:0];
          gfp_pkg::REG_HOLD_TICKS: hold_limit = pwdata[15:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall)
        parse_beat(action, rx_byte);

      if (out_valid && !out_stall) begin
        if (due_reports.size() == 0) begin
          if (miss_count < 10)
            $display("%0t: result beat with none due: kind=%0d key=%02h dir=%0d l=%0d r=%0d",
                     $realtime, kind, key_code, direction, left_pwm, right_pwm);
          miss_count++;
        end else begin
          exp_rep = due_reports.pop_front();
          if (exp_rep.kind !== kind || exp_rep.key_code !== key_code ||
              exp_rep.direction !== direction || exp_rep.left_pwm !== left_pwm ||
              exp_rep.right_pwm !== right_pwm) begin
            if (miss_count < 10)
              $display("%0t: mismatch exp kind=%0d key=%02h dir=%0d l=%0d r=%0d / got kind=%0d key=%02h dir=%0d l=%0d r=%0d",
                       $realtime, exp_rep.kind, exp_rep.key_code, exp_rep.direction,
                       exp_rep.left_pwm, exp_rep.right_pwm,
                       kind, key_code, direction, left_pwm, right_pwm);
            miss_count++;
          end
        end
      end
    end
    pending <= due_reports.size();
    errors  <= miss_count;
  end

endmodule

[tb/tb.sv]
// Testbench top: clock, reset, register writes, input beats, output stalls and the verdict.
`timescale 1ns / 100ps

module tb;
  import gfp_tb_pkg::*;

  localparam int LIMIT = 1_000_000;  // cycles; far above the slowest legal run
  localparam int SETTLE = 40;        // > longest decode plus handoff

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic                       action;
  logic [7:0]                 rx_byte;
  logic                       out_valid;
  logic                       out_stall;
  logic                       kind;
  logic [7:0]                 key_code;
  logic [3:0]                 direction;
  logic [7:0]                 left_pwm;
  logic [7:0]                 right_pwm;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [gfp_pkg::ADDR_W-1:0] paddr;
  logic [63:0]                pwdata;
  logic [63:0]                prdata;
  logic                       pready;

  int pending;
  int errors;
  int cycles = 0;
  int beats_sent = 0;

  // our copy of the registers, used to build frames that the parser accepts
  logic [63:0] keys_low_q  = '0;
  logic [15:0] keys_high_q = '0;
  logic [15:0] hold_q      = gfp_pkg::HOLD_RESET;

  bit no_idle = 1'b0;        // sender burst mode: no gaps between beats
  bit pressure_req = 1'b0;   // asks the receiver for one long hold-off
  bit pressure_done = 1'b0;

  always #5 clk = ~clk;

  gamepad_frame_parser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .key_code  (key_code),
    .direction (direction),
    .left_pwm  (left_pwm),
    .right_pwm (right_pwm),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  gfp_report_checker watch (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .key_code  (key_code),
    .direction (direction),
    .left_pwm  (left_pwm),
    .right_pwm (right_pwm),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pending   (pending),
    .errors    (errors)
  );

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall in segments. Mostly short free runs and short stalls, now
  // and then a long stall or a long free stretch. Once, on request, one very
  // long hold-off so the output register fills and in_stall backs up the input.
  // ---------------------------------------------------------------------------
  initial begin
    int r;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (pressure_req && !pressure_done) begin
        pressure_done = 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else begin
        r = $urandom_range(0, 9);
        if (r < 5) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (r < 8) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else if (r < 9) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end else begin
          out_stall <= 1'b0;
          repeat ($urandom_range(50, 100)) @(posedge clk);
        end
      end
    end
  end

  function automatic logic [7:0] key_of(int slot);
    return (slot < 8) ? keys_low_q[8*slot +: 8] : keys_high_q[8*(slot-8) +: 8];
  endfunction

  // sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // field content: digits, hex letters, plain zeros, any byte now and then
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8)  return gfp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    if (r < 12) return 8'h41 + 8'($urandom_range(0, 5));
    if (r < 16) return gfp_pkg::CH_ZERO;
    return 8'($urandom);
  endfunction

  // ticks that reach the hold time; a huge hold time is never waited out
  function automatic int hold_span();
    return (hold_q > 8) ? $urandom_range(1, 4) : int'(hold_q);
  endfunction

  // One beat. The payload stays put until accepted. When no gap follows,
  // valid stays high and only the payload changes at the accepting edge.
  task automatic send_beat(logic act, logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_beat(ACT_TICK, 8'($urandom));
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_beat(ACT_BYTE, s[i]);
  endtask

  task automatic reg_write(logic [gfp_pkg::REG_IDX_W-1:0] idx, logic [63:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_regs(logic [63:0] lo, logic [15:0] hi, logic [15:0] hold);
    reg_write(gfp_pkg::REG_KEY_LOW, lo);
    reg_write(gfp_pkg::REG_KEY_HIGH, {48'h0, hi});
    reg_write(gfp_pkg::REG_HOLD_TICKS, {48'h0, hold});
    keys_low_q  = lo;
    keys_high_q = hi;
    hold_q      = hold;
  endtask

  // Drop valid, wait for every due result, then let the decoder settle: a
  // beat with no result may still be in flight when the last result leaves.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Joystick frame: left key, four fields of L-1 chars, separators between.
  // In hex frames the first separator (byte 3) is the right key; in decimal
  // frames byte 3 is field content and must not equal the right key.
  // split_at inserts enough ticks after 2-3 bytes to classify a short frame
  // that keeps waiting; extra appends bytes past the full length.
  task automatic send_stick(bit hex, int extra, int split_at);
    logic [7:0] fr [$];
    int         len;
    bit         blank;
    len = hex ? 3 : 4;
    fr.push_back(key_of(KEY_LEFT));
    for (int h = 0; h < 4; h++) begin
      blank = ($urandom_range(0, 3) == 0);
      for (int k = 1; k < len; k++) fr.push_back(blank ? gfp_pkg::CH_ZERO : pick_char());
      if (h < 3) fr.push_back((hex && h == 0) ? key_of(KEY_RIGHT) : 8'($urandom));
    end
    if (!hex && fr[3] == key_of(KEY_RIGHT)) fr[3] = fr[3] ^ 8'h01;
    repeat (extra) fr.push_back(8'($urandom));
    foreach (fr[i]) begin
      if (split_at != 0 && i == split_at) send_ticks(hold_span() + 1);
      send_beat(ACT_BYTE, fr[i]);
    end
    send_ticks(hold_span() + $urandom_range(0, 2));
  endtask

  // Random part: mostly well-formed frames with random content, the rest
  // keypad presses, broken frames and raw noise.
  task automatic run_random(int quota);
    int first;
    int r;
    first = beats_sent;
    while (beats_sent - first < quota) begin
      if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
      r = $urandom_range(0, 99);
      if (r < 20) begin
        send_beat(ACT_BYTE, key_of($urandom_range(0, 9)));
        send_ticks(hold_span() + $urandom_range(0, 1));
      end else if (r < 40) begin
        send_stick(1'b1, 0, 0);
      end else if (r < 60) begin
        send_stick(1'b0, 0, 0);
      end else if (r < 70) begin
        send_stick($urandom_range(0, 1), 0, $urandom_range(2, 3));
      end else if (r < 74) begin
        send_stick(1'b1, $urandom_range(1, 4), 0);   // overlong hex
      end else if (r < 78) begin
        send_stick(1'b0, $urandom_range(1, 2), 0);   // decimal past the buffer
      end else if (r < 83) begin
        // buffer overflow: the seventeenth byte clears the frame
        send_beat(ACT_BYTE, key_of(KEY_LEFT));
        repeat ($urandom_range(16, 18)) send_beat(ACT_BYTE, 8'($urandom));
        send_ticks(hold_span());
      end else if (r < 90) begin
        // frame led by a key other than left
        send_beat(ACT_BYTE, key_of($urandom_range(2, 9)));
        repeat ($urandom_range(1, 5)) send_beat(ACT_BYTE, pick_char());
        send_ticks(hold_span() + 1);
      end else begin
        repeat ($urandom_range(1, 6))
          send_beat($urandom_range(0, 1) ? ACT_TICK : ACT_BYTE, 8'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    action   <= ACT_BYTE;
    rx_byte  <= 8'h00;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset values: all key codes are 0x00, hold is 100 ticks. 0x55 is no
    // key and is dropped; 0x00 is one and comes out after exactly 100 ticks.
    send_beat(ACT_BYTE, 8'h55);
    send_beat(ACT_BYTE, 8'h00);
    send_ticks(100);
    drain();

    // Directed: readable key codes, hold of one tick.
    set_regs("BATSDURL", "XY", 16'd1);
    send_beat(ACT_BYTE, 8'hFF);          // invalid first byte
    send_beat(ACT_TICK, 8'h00);          // tick on an empty buffer
    send_text("U");                      // keypad press
    send_beat(ACT_TICK, 8'hFF);
    send_text("D");                      // multi-byte frame, wrong first key
    send_beat(ACT_BYTE, 8'h00);
    send_beat(ACT_TICK, 8'h00);
    send_text("L00RFF,99,00");           // hex stick: turn right, forward
    send_beat(ACT_TICK, 8'h00);
    drain();

    // all-ones keys: left and right keys coincide
    set_regs('1, '1, 16'd2);
    run_random(200);
    drain();

    // hold of zero: every key byte is a keypad press at once, so the long
    // receiver hold-off here backs the results up into the input
    set_regs({$urandom, $urandom}, 16'($urandom), 16'd0);
    pressure_req = 1'b1;
    run_random(250);
    drain();

    // maximum hold: frames never classify, only overflow clears them
    set_regs({$urandom, $urandom}, 16'($urandom), 16'hFFFF);
    run_random(60);
    drain();

    repeat (4) begin
      set_regs({$urandom, $urandom}, 16'($urandom), 16'($urandom_range(1, 4)));
      run_random(300);
      drain();
    end

    if (pending != 0)
      $display("%0d expected results never arrived", pending);
    if (errors == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/gfp_pkg.sv
design/gfp_cfg.sv
design/gfp_frame.sv
design/gfp_decode.sv
design/gamepad_frame_parser.sv
tb/gfp_tb_pkg.sv
tb/gfp_report_checker.sv
tb/tb.sv
